// ----- rtl/core/c3nc_pkg.sv -----
// c3nc_pkg: types, widths and constants of the normalized 3x3 convolution
// no dependencies; used by the interfaces, the datapath modules and the checker
`default_nettype none

package c3nc_pkg;

  localparam int PIX_W    = 8;
  localparam int COEF_W   = 16;
  localparam int NTAP     = 9;
  localparam int NROW     = 3;
  localparam int NCOL     = 3;
  localparam int ROW_W    = NCOL * COEF_W;
  localparam int PROD_W   = 24;   // pixel times coefficient, signed
  localparam int RSUM_W   = 26;   // three products
  localparam int ACC_W    = 28;   // nine products
  localparam int MAG_W    = 27;   // magnitude of the product sum
  localparam int Q_W      = 16;   // quotient bits produced by the divider chain
  localparam int DROW_W   = 18;   // three coefficients
  localparam int DSUM_W   = 20;   // nine coefficients
  localparam int DIV_W    = 19;   // magnitude of the divisor
  localparam int REM_W    = DIV_W;
  localparam int HI_W     = MAG_W - Q_W;
  localparam int NFRONT   = 4;
  localparam int NCELL    = Q_W;
  localparam int NSTAGE   = NFRONT + NCELL + 1;
  localparam int RES_W    = 16;

  localparam logic [RES_W-1:0] PIX_MAX = RES_W'(255);
  localparam logic [RES_W-1:0] S_MAX   = 16'h7FFF;
  localparam logic [RES_W-1:0] S_MIN   = 16'h8000;

  typedef enum logic [1:0] {
    REG_COEF_TOP   = 2'd0,
    REG_COEF_MID   = 2'd1,
    REG_COEF_BOT   = 2'd2,
    REG_OUT_SIGNED = 2'd3
  } cfg_idx_t;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix_top_left;
    logic [PIX_W-1:0] pix_top_mid;
    logic [PIX_W-1:0] pix_top_right;
    logic [PIX_W-1:0] pix_mid_left;
    logic [PIX_W-1:0] pix_mid_mid;
    logic [PIX_W-1:0] pix_mid_right;
    logic [PIX_W-1:0] pix_bot_left;
    logic [PIX_W-1:0] pix_bot_mid;
    logic [PIX_W-1:0] pix_bot_right;
  } in_item_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result_value;
  } out_item_t;

  // one step of the long division: partial remainder, remaining dividend
  // bits on the left and quotient bits filling in from the right
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   lq;
    logic             neg;
    logic             ovf;
  } div_stage_t;

endpackage

`default_nettype wire

// ----- rtl/core/c3nc_in_if.sv -----
// c3nc_in_if: window item channel, valid/ready with the nine pixels
// depends on c3nc_pkg
`default_nettype none

interface c3nc_in_if import c3nc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/c3nc_out_if.sv -----
// c3nc_out_if: result item channel, valid/ready with the saturated quotient
// depends on c3nc_pkg
`default_nettype none

interface c3nc_out_if import c3nc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/c3nc_cfg_if.sv -----
// c3nc_cfg_if: register write channel, valid/ready with index and data
// depends on c3nc_pkg
`default_nettype none

interface c3nc_cfg_if import c3nc_pkg::*; ();
  logic             valid;
  logic             ready;
  cfg_idx_t         index;
  logic [ROW_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/conv3x3_normalized_clamp.sv -----
// conv3x3_normalized_clamp: normalized 3x3 convolution with saturation
// depends on c3nc_pkg, the three channel interfaces, c3nc_front, c3nc_div_cell
//
//   channel  dir  payload                                  accepted when
//   cfg_if   in   index (2b), data (48b)                   valid & ready (ready tied high)
//   in_if    in   nine 8-bit unsigned pixels               valid & ready
//   out_if   out  result_value (16b signed)                valid & ready
//
// one item per cycle sustained while out_if is not stalled; from input accept to
// output valid an item passes 4 front stages (products, row sums, total, magnitude),
// 16 divider cells (one quotient bit each) and the saturating output register
// the divisor is rebuilt from the coefficient registers through registered row sums, total, magnitude and sign
// synchronous active-low reset clears valids, coefficients and mode
// every stage moves on when it is empty or the next one moves, so bubbles
// close up and input is taken while a result waits at the output
`default_nettype none

module conv3x3_normalized_clamp import c3nc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  c3nc_cfg_if.sink    cfg_if,
  c3nc_in_if.sink     in_if,
  c3nc_out_if.source  out_if
);

  // configuration registers
  logic [ROW_W-1:0]         coef_row_r [NROW];
  logic                     osgn_r;
  coef_t                    coef       [NTAP];

  // divisor pipeline: row sums, total, magnitude and sign
  logic signed [DROW_W-1:0] drow_nxt   [NROW];
  logic signed [DROW_W-1:0] drow_r     [NROW];
  logic signed [DSUM_W-1:0] dtot_nxt;
  logic signed [DSUM_W-1:0] dtot_r;
  logic [DSUM_W-1:0]        dmag;
  logic [DIV_W-1:0]         dabs_nxt;
  logic [DIV_W-1:0]         dabs_r;
  logic                     dneg_r;

  // stage valids and enables, stage NSTAGE-1 is the output register
  logic [NSTAGE-1:0]        v;
  logic [NSTAGE-1:0]        en;
  logic [NFRONT-1:0]        front_v;
  logic [NCELL:0]           cv;
  div_stage_t               st [NCELL+1];

  logic                     out_v_r;
  logic [RES_W-1:0]         res_nxt;
  logic [RES_W-1:0]         res_r;
  logic [Q_W-1:0]           q;

  // register writes, always ready
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NROW; r++) coef_row_r[r] <= '0;
      osgn_r <= 1'b0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_COEF_TOP:   coef_row_r[0] <= cfg_if.data;
        REG_COEF_MID:   coef_row_r[1] <= cfg_if.data;
        REG_COEF_BOT:   coef_row_r[2] <= cfg_if.data;
        REG_OUT_SIGNED: osgn_r        <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

  // coefficient at row r, column c sits at bits 16c+15:16c of row r
  always_comb begin
    for (int r = 0; r < NROW; r++) begin
      for (int c = 0; c < NCOL; c++) begin
        coef[r*NCOL+c] = coef_t'(coef_row_r[r][c*COEF_W +: COEF_W]);
      end
    end
  end

  // divisor: coefficient sum, zero sum replaced by one
  always_comb begin
    for (int r = 0; r < NROW; r++) begin
      drow_nxt[r] = DROW_W'(coef[r*NCOL]) + DROW_W'(coef[r*NCOL+1])
                  + DROW_W'(coef[r*NCOL+2]);
    end
    dtot_nxt = DSUM_W'(drow_r[0]) + DSUM_W'(drow_r[1]) + DSUM_W'(drow_r[2]);
    dmag     = dtot_r[DSUM_W-1] ? DSUM_W'(-dtot_r) : DSUM_W'(dtot_r);
    dabs_nxt = (dtot_r == '0) ? DIV_W'(1) : dmag[DIV_W-1:0];
  end

  // registered row sums, total, magnitude and sign follow the coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NROW; r++) drow_r[r] <= '0;
      dtot_r <= '0;
      dabs_r <= DIV_W'(1);
      dneg_r <= 1'b0;
    end else begin
      for (int r = 0; r < NROW; r++) drow_r[r] <= drow_nxt[r];
      dtot_r <= dtot_nxt;
      dabs_r <= dabs_nxt;
      dneg_r <= dtot_r[DSUM_W-1];
    end
  end

  // stage k may load when any stage from k on is empty or the output drains
  assign v = {out_v_r, cv[NCELL:1], front_v};

  always_comb begin
    for (int k = 0; k < NSTAGE; k++) begin
      en[k] = out_if.ready || (|((~v) >> k));
    end
  end

  assign in_if.ready = en[0];

  c3nc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en[NFRONT-1:0]),
    .in_valid (in_if.valid),
    .pix      (in_if.data),
    .coef     (coef),
    .dabs     (dabs_r),
    .dneg     (dneg_r),
    .v        (front_v),
    .st       (st[0])
  );

  assign cv[0] = front_v[NFRONT-1];

  // divider chain, cell g resolves quotient bit Q_W-1-g
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    c3nc_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en[NFRONT+g]),
      .in_valid  (cv[g]),
      .in_st     (st[g]),
      .dabs      (dabs_r),
      .out_valid (cv[g+1]),
      .out_st    (st[g+1])
    );
  end

  // saturation; an overflow flag means the quotient magnitude is 2^16 or more
  always_comb begin
    q = st[NCELL].lq;
    if (osgn_r) begin
      if (st[NCELL].neg) begin
        if (st[NCELL].ovf || (q > S_MIN)) res_nxt = S_MIN;
        else                              res_nxt = RES_W'(-q);
      end else begin
        if (st[NCELL].ovf || (q > S_MAX)) res_nxt = S_MAX;
        else                              res_nxt = q;
      end
    end else begin
      if (st[NCELL].neg)                    res_nxt = '0;
      else if (st[NCELL].ovf || (q > PIX_MAX)) res_nxt = PIX_MAX;
      else                                  res_nxt = q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en[NSTAGE-1]) begin
      out_v_r <= cv[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTAGE-1]) res_r <= res_nxt;
  end

  assign out_if.valid             = out_v_r;
  assign out_if.data.result_value = res_r;

endmodule

`default_nettype wire

// ----- rtl/core/c3nc_front.sv -----
// c3nc_front: product lanes, row sums, total and magnitude/overflow stage
// depends on c3nc_pkg; feeds the first divider cell
`default_nettype none

module c3nc_front import c3nc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [NFRONT-1:0] en,
  input  wire logic              in_valid,
  input  wire in_item_t          pix,
  input  wire coef_t             coef [NTAP],
  input  wire logic [DIV_W-1:0]  dabs,
  input  wire logic              dneg,
  output logic      [NFRONT-1:0] v,
  output div_stage_t             st
);

  logic [NFRONT-1:0]        v_r;
  logic [PIX_W-1:0]         p      [NTAP];
  logic signed [PROD_W:0]   full   [NTAP];
  logic signed [PROD_W-1:0] prod_r [NTAP];
  logic signed [RSUM_W-1:0] rsum_nxt [NROW];
  logic signed [RSUM_W-1:0] rsum_r [NROW];
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]         mag_full;
  logic [MAG_W-1:0]         mag;
  div_stage_t               st_nxt;
  div_stage_t               st_r;

  assign p[0] = pix.pix_top_left;
  assign p[1] = pix.pix_top_mid;
  assign p[2] = pix.pix_top_right;
  assign p[3] = pix.pix_mid_left;
  assign p[4] = pix.pix_mid_mid;
  assign p[5] = pix.pix_mid_right;
  assign p[6] = pix.pix_bot_left;
  assign p[7] = pix.pix_bot_mid;
  assign p[8] = pix.pix_bot_right;

  always_comb begin
    for (int i = 0; i < NTAP; i++) begin
      full[i] = $signed({1'b0, p[i]}) * coef[i];
    end
    for (int r = 0; r < NROW; r++) begin
      rsum_nxt[r] = RSUM_W'(prod_r[r*NCOL]) + RSUM_W'(prod_r[r*NCOL+1])
                  + RSUM_W'(prod_r[r*NCOL+2]);
    end
    acc_nxt = ACC_W'(rsum_r[0]) + ACC_W'(rsum_r[1]) + ACC_W'(rsum_r[2]);
  end

  // magnitude split: high bits start the remainder, low bits go through the cells
  always_comb begin
    mag_full   = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    mag        = mag_full[MAG_W-1:0];
    st_nxt.rem = {{(REM_W-HI_W){1'b0}}, mag[MAG_W-1:Q_W]};
    st_nxt.lq  = mag[Q_W-1:0];
    st_nxt.neg = acc_r[ACC_W-1] ^ dneg;
    st_nxt.ovf = ({{(DIV_W-HI_W){1'b0}}, mag[MAG_W-1:Q_W]} >= dabs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NFRONT; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < NTAP; i++) prod_r[i] <= full[i][PROD_W-1:0];
    end
    if (en[1]) begin
      for (int r = 0; r < NROW; r++) rsum_r[r] <= rsum_nxt[r];
    end
    if (en[2]) acc_r <= acc_nxt;
    if (en[3]) st_r <= st_nxt;
  end

  assign v  = v_r;
  assign st = st_r;

endmodule

`default_nettype wire

// ----- rtl/core/c3nc_div_cell.sv -----
// c3nc_div_cell: one restoring division step, one quotient bit per cell
// depends on c3nc_pkg; chained sixteen deep in the top level
`default_nettype none

module c3nc_div_cell import c3nc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire div_stage_t       in_st,
  input  wire logic [DIV_W-1:0] dabs,
  output logic                  out_valid,
  output div_stage_t            out_st
);

  logic             valid_r;
  div_stage_t       st_r;
  div_stage_t       st_nxt;
  logic [REM_W:0]   trial;
  logic [REM_W+1:0] diff;
  logic             ge;

  always_comb begin
    trial      = {in_st.rem, in_st.lq[Q_W-1]};
    diff       = {1'b0, trial} - {2'b00, dabs};
    ge         = !diff[REM_W+1];
    st_nxt.rem = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    st_nxt.lq  = {in_st.lq[Q_W-2:0], ge};
    st_nxt.neg = in_st.neg;
    st_nxt.ovf = in_st.ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) st_r <= st_nxt;
  end

  assign out_valid = valid_r;
  assign out_st    = st_r;

endmodule

`default_nettype wire

// ----- rtl/core/c3nc_chk.sv -----
// c3nc_chk: port-level checks of the convolution block, bound to the top level
// depends on c3nc_pkg
`default_nettype none

module c3nc_chk import c3nc_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             cfg_valid,
  input wire logic             cfg_ready,
  input wire cfg_idx_t         cfg_index,
  input wire logic [ROW_W-1:0] cfg_data,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire out_item_t        out_data
);

  localparam int CNT_W = $clog2(NSTAGE + 1);

  logic             in_acc;
  logic             out_acc;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             mode_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc)  cnt_nxt = cnt_nxt + CNT_W'(1);
    if (out_acc) cnt_nxt = cnt_nxt - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      mode_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_valid && cfg_ready && (cfg_index == REG_OUT_SIGNED)) mode_r <= cfg_data[0];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cnt_r != '0))
    else $error("result with no item in flight");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (cnt_r < CNT_W'(NSTAGE)) || out_acc)
    else $error("item taken beyond pipeline capacity");

  a_pix_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !mode_r |-> (out_data.result_value[RES_W-1:PIX_W] == '0))
    else $error("unsigned mode result above 255 or negative");

endmodule

bind conv3x3_normalized_clamp c3nc_chk u_c3nc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .cfg_valid (cfg_if.valid),
  .cfg_ready (cfg_if.ready),
  .cfg_index (cfg_if.index),
  .cfg_data  (cfg_if.data),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);

`default_nettype wire

// ----- verif/testbench.sv -----
// testbench for conv3x3_normalized_clamp: directed and random windows through the filter
// depends on c3nc_pkg and the cfg, in and out channel interfaces of the rtl
// results are checked in order against a predictor of the normalized clamped sum

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import c3nc_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 5;
  // pipeline depth plus margin, waited out before register writes and at the end
  localparam int DRAIN_CYCLES   = NSTAGE + 8;
  // time for the divisor to be rebuilt from the coefficient registers
  localparam int REBUILD_CYCLES = NROW + 2;
  // cycles with no item moving on any channel before the run is called hung
  localparam int QUIET_LIMIT    = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_PHASES  = 16;
  localparam int CALM_PHASES    = 2;
  localparam int PHASE_WINDOWS  = 100;

  logic clk = 1'b0;
  logic rst_n;

  c3nc_cfg_if cfg_bus ();
  c3nc_in_if  in_bus ();
  c3nc_out_if out_bus ();

  conv3x3_normalized_clamp u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_bus),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow copy of the register file, updated when a write is accepted
  logic [ROW_W-1:0] coef_shadow [NROW] = '{default: '0};
  logic             signed_shadow      = 1'b0;

  // quotients still owed by the block, oldest first
  logic signed [RES_W-1:0] pending_results [$];

  int  windows_sent     = 0;
  int  results_checked  = 0;
  int  mismatches       = 0;
  int  settings_applied = 0;
  int  signed_settings  = 0;
  int  quiet_cycles     = 0;
  int  ready_hold       = 0;
  bit  stall_enable     = 1'b1;

  // normalized convolution of one window under the shadow registers
  function automatic logic signed [RES_W-1:0] filter_window(in_item_t w);
    logic [NTAP*PIX_W-1:0] flat;
    coef_t  k;
    longint prod_sum;
    longint weight_sum;
    longint quot;
    flat       = w;
    prod_sum   = 0;
    weight_sum = 0;
    for (int r = 0; r < NROW; r++) begin
      for (int c = 0; c < NCOL; c++) begin
        k = coef_t'(coef_shadow[r][c*COEF_W +: COEF_W]);
        weight_sum += longint'(k);
        // top left pixel sits in the most significant byte of the packed item
        prod_sum += longint'(k) * longint'(flat[(NTAP-1-(r*NCOL+c))*PIX_W +: PIX_W]);
      end
    end
    // zero weight sum: the raw product sum is clamped instead
    if (weight_sum == 0) begin
      weight_sum = 1;
    end
    quot = prod_sum / weight_sum;
    if (signed_shadow) begin
      if (quot > longint'($signed(S_MAX))) begin
        quot = longint'($signed(S_MAX));
      end else if (quot < longint'($signed(S_MIN))) begin
        quot = longint'($signed(S_MIN));
      end
    end else begin
      if (quot > longint'(PIX_MAX)) begin
        quot = longint'(PIX_MAX);
      end else if (quot < 0) begin
        quot = 0;
      end
    end
    return RES_W'(quot);
  endfunction

  function automatic void note_mismatch(string what, logic signed [RES_W-1:0] want,
                                        logic signed [RES_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] %s: result_value expected %0d got %0d (result %0d)",
               $realtime, what, want, got, results_checked);
    end
  endfunction

  // channel monitor: register shadow, result check and expectation capture,
  // all sampled at the rising edge before any of this edge's updates land
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_COEF_TOP:   coef_shadow[0] = cfg_bus.data;
          REG_COEF_MID:   coef_shadow[1] = cfg_bus.data;
          REG_COEF_BOT:   coef_shadow[2] = cfg_bus.data;
          REG_OUT_SIGNED: signed_shadow  = cfg_bus.data[0];
          default: ;
        endcase
      end
      if (out_bus.valid && out_bus.ready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          note_mismatch("result with no window pending", 'x, out_bus.data.result_value);
        end else if (out_bus.data.result_value !== pending_results[0]) begin
          note_mismatch("wrong result", pending_results[0], out_bus.data.result_value);
          void'(pending_results.pop_front());
        end else begin
          void'(pending_results.pop_front());
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        pending_results.push_back(filter_window(in_bus.data));
      end
    end
  end

  // result side backpressure: random bursts of low ready
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (stall_enable && $urandom_range(0, 6) == 0) begin
      out_bus.ready <= 1'b0;
      ready_hold    <= $urandom_range(0, 5);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // hang detector: any accepted item on any channel resets the count
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] no item moved for %0d cycles, %0d results outstanding",
               $realtime, quiet_cycles, pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [ROW_W-1:0] row_of(coef_t left, coef_t mid, coef_t right);
    return {right, mid, left};
  endfunction

  function automatic in_item_t window_of(logic [PIX_W-1:0] tl, tm, tr, ml, mm, mr,
                                         bl, bm, br);
    return '{tl, tm, tr, ml, mm, mr, bl, bm, br};
  endfunction

  // pixels lean toward the rails so clamping and full products show up often
  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_window();
    return window_of(random_pixel(), random_pixel(), random_pixel(),
                     random_pixel(), random_pixel(), random_pixel(),
                     random_pixel(), random_pixel(), random_pixel());
  endfunction

  // send one window; valid stays high from item to item unless a gap is taken
  task automatic push_window(in_item_t w);
    if (stall_enable && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= w;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    windows_sent++;
  endtask

  // one register write; cfg valid is left high for a following write
  task automatic put_register(cfg_idx_t idx, logic [ROW_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
  endtask

  // full register update, only with the pipeline empty
  task automatic load_kernel(logic [ROW_W-1:0] top, logic [ROW_W-1:0] mid,
                             logic [ROW_W-1:0] bot, logic [ROW_W-1:0] mode_word);
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    put_register(REG_COEF_TOP, top);
    put_register(REG_COEF_MID, mid);
    put_register(REG_COEF_BOT, bot);
    // only bit 0 of the mode word counts, the rest is noise
    put_register(REG_OUT_SIGNED, mode_word);
    cfg_bus.valid <= 1'b0;
    repeat (REBUILD_CYCLES) @(posedge clk);
    settings_applied++;
    if (mode_word[0]) begin
      signed_settings++;
    end
  endtask

  // reset leaves all coefficients zero: zero weight sum and zero product sum
  task automatic test_reset_state();
    push_window(window_of('1, '1, '1, '1, '1, '1, '1, '1, '1));
    push_window(random_window());
  endtask

  // centre tap only: the result is the centre pixel
  task automatic test_identity();
    load_kernel(row_of(0, 0, 0), row_of(0, 1, 0), row_of(0, 0, 0), 48'hFFFF_FFFF_FFFE);
    push_window(window_of('1, '1, '1, '1, 8'h00, '1, '1, '1, '1));
    push_window(window_of(8'h00, 8'h00, 8'h00, 8'h00, 8'hA5, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  // box filter: the truncated mean of the window
  task automatic test_box_average();
    load_kernel(row_of(1, 1, 1), row_of(1, 1, 1), row_of(1, 1, 1), 48'h0);
    push_window(window_of('1, '1, '1, '1, '1, '1, '1, '1, '1));
    push_window(window_of(8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9));
  endtask

  // kernels whose weights cancel: the raw product sum is clamped
  task automatic test_zero_weight_sum();
    // laplacian, unsigned clamp at both rails
    load_kernel(row_of(0, -1, 0), row_of(-1, 4, -1), row_of(0, -1, 0), 48'h8000_0000_0000);
    push_window(window_of(8'h00, 8'h00, 8'h00, 8'h00, '1, 8'h00, 8'h00, 8'h00, 8'h00));
    push_window(window_of('1, '1, '1, '1, 8'h00, '1, '1, '1, '1));
    // same kernel, signed mode keeps the sign and magnitude
    load_kernel(row_of(0, -1, 0), row_of(-1, 4, -1), row_of(0, -1, 0), 48'h5A5A_0000_0001);
    push_window(window_of(8'h00, 8'h00, 8'h00, 8'h00, '1, 8'h00, 8'h00, 8'h00, 8'h00));
    push_window(window_of('1, '1, '1, '1, 8'h00, '1, '1, '1, '1));
    // full scale taps that cancel: signed clamp at both rails
    load_kernel(row_of(coef_t'(16'h7FFF), coef_t'(16'h8000), 1), row_of(0, 0, 0),
                row_of(0, 0, 0), 48'h1);
    push_window(window_of('1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    push_window(window_of(8'h00, '1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  // coefficient rails and truncation toward zero with a negative divisor
  task automatic test_coef_extremes();
    load_kernel({3{coef_t'(16'h7FFF)}}, {3{coef_t'(16'h7FFF)}}, {3{coef_t'(16'h7FFF)}}, 48'h1);
    push_window(window_of('1, '1, '1, '1, '1, '1, '1, '1, '1));
    load_kernel({3{coef_t'(16'h8000)}}, {3{coef_t'(16'h8000)}}, {3{coef_t'(16'h8000)}}, 48'h1);
    push_window(window_of('1, '1, '1, '1, '1, 8'h00, '1, 8'h7F, '1));
    // weight sum -2: 3 / -2 must give -1, not -2
    load_kernel(row_of(-3, 0, 0), row_of(0, 1, 0), row_of(0, 0, 0), 48'h1);
    push_window(window_of(8'd1, 8'd9, 8'd9, 8'd9, 8'd0, 8'd9, 8'd9, 8'd9, 8'd9));
    push_window(window_of(8'd0, 8'd9, 8'd9, 8'd9, 8'd3, 8'd9, 8'd9, 8'd9, 8'd9));
  endtask

  // random kernels of several kinds, random windows, gaps on both sides
  // until the last phases, which run at full rate
  task automatic test_random_windows();
    coef_t k [NTAP];
    int    kind;
    int    weight_sum;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      kind = $urandom_range(0, 4);
      weight_sum = 0;
      for (int t = 0; t < NTAP; t++) begin
        case (kind)
          0: k[t] = coef_t'($urandom);
          1, 2: k[t] = coef_t'(int'($urandom_range(0, 6)) - 3);
          3: begin
            case ($urandom_range(0, 4))
              0:       k[t] = coef_t'(16'h7FFF);
              1:       k[t] = coef_t'(16'h8000);
              2:       k[t] = coef_t'(16'hFFFF);
              3:       k[t] = coef_t'(16'h0001);
              default: k[t] = coef_t'(16'h0000);
            endcase
          end
          default: k[t] = coef_t'($urandom_range(0, 8));
        endcase
        if (t != NTAP / 2) begin
          weight_sum += int'(k[t]);
        end
      end
      // balanced kind: centre tap cancels the other eight
      if (kind == 2) begin
        k[NTAP/2] = coef_t'(-weight_sum);
      end
      if (phase >= RANDOM_PHASES - CALM_PHASES) begin
        stall_enable = 1'b0;
      end
      load_kernel(row_of(k[0], k[1], k[2]), row_of(k[3], k[4], k[5]),
                  row_of(k[6], k[7], k[8]),
                  {16'($urandom), 31'($urandom), 1'($urandom)});
      repeat (PHASE_WINDOWS) push_window(random_window());
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_COEF_TOP;
    cfg_bus.data  = '0;
    out_bus.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_identity();
    test_box_average();
    test_zero_weight_sum();
    test_coef_extremes();
    test_random_windows();

    // let the pipeline empty, then watch a little longer for stray results
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d windows filtered, %0d results compared, %0d mismatches",
             windows_sent, results_checked, mismatches);
    $display("%0d register settings loaded, %0d of them with signed clamping",
             settings_applied, signed_settings);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
